// File: rtl/lfd_pkg.sv
// ----------------------------------------------------------------------------
// lfd_pkg
// Shared types and constants of the line frame decoder.
// ----------------------------------------------------------------------------
package lfd_pkg;

  localparam int unsigned LfdLengthWidth    = 16;
  localparam int unsigned LfdQueueDepth     = 4;
  localparam int unsigned LfdMaxLengthReset = 4096;

  localparam logic [7:0] LfdByteLf = 8'h0A;
  localparam logic [7:0] LfdByteCr = 8'h0D;

  // Register indexes of the configuration channel
  typedef enum logic [1:0] {
    LfdRegMaxLength = 2'd0,
    LfdRegStrip     = 2'd1,
    LfdRegMode      = 2'd2
  } lfd_reg_e;

  // Terminator modes; the unused code behaves as LfdModeAny
  typedef enum logic [1:0] {
    LfdModeAny     = 2'd0,
    LfdModeLfOnly  = 2'd1,
    LfdModeCrLfOnly = 2'd2
  } lfd_mode_e;

  // One result, without the run marker (the back end adds it)
  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       frame_end;
    logic       overflow;
  } lfd_result_t;

  // Everything one input byte causes: one or two results
  typedef struct packed {
    lfd_result_t second;
    lfd_result_t first;
    logic        two;
  } lfd_entry_t;

endpackage

// File: rtl/lfd_front.sv
// ----------------------------------------------------------------------------
// lfd_front
// Accepts bytes, classifies them and tracks the line state; emits the
// results of each byte as one queue entry.
// ----------------------------------------------------------------------------
module lfd_front #(
  parameter int unsigned LENGTH_WIDTH = lfd_pkg::LfdLengthWidth
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [1:0]              cfg_index_i,
  input  logic [LENGTH_WIDTH-1:0] cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [7:0]              in_byte_i,
  input  logic                    queue_full_i,
  output logic                    push_o,
  output lfd_pkg::lfd_entry_t     push_entry_o
);
  import lfd_pkg::*;

  localparam logic [LENGTH_WIDTH-1:0] MaxLengthRst = LENGTH_WIDTH'(LfdMaxLengthReset);

  logic [LENGTH_WIDTH-1:0] max_length_q;
  logic                    strip_q;
  logic [1:0]              mode_q;

  logic [LENGTH_WIDTH-1:0] len_q, len_d, len_a;
  logic                    cr_q, cr_d;
  logic                    disc_q, disc_d, disc_a;

  logic        accept;
  logic        crlf_ok, lf_ok, is_lf, is_cr;
  logic        ra_v, rb0_v, rb1_v;
  lfd_result_t ra, rb0, rb1;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !queue_full_i;
  assign accept      = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_length_q <= MaxLengthRst;
      strip_q      <= 1'b1;
      mode_q       <= LfdModeAny;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        LfdRegMaxLength: max_length_q <= cfg_data_i;
        LfdRegStrip:     strip_q      <= cfg_data_i[0];
        LfdRegMode:      mode_q       <= cfg_data_i[1:0];
        default:         ;
      endcase
    end
  end

  assign crlf_ok = (mode_q != LfdModeLfOnly);
  assign lf_ok   = (mode_q != LfdModeCrLfOnly);
  assign is_lf   = (in_byte_i == LfdByteLf);
  assign is_cr   = (in_byte_i == LfdByteCr);

  always_comb begin
    ra_v   = 1'b0;
    rb0_v  = 1'b0;
    rb1_v  = 1'b0;
    ra     = '0;
    rb0    = '0;
    rb1    = '0;
    cr_d   = cr_q;
    disc_d = disc_q;
    len_d  = len_q;
    disc_a = disc_q;
    len_a  = len_q;
    if (cr_q && is_lf && crlf_ok) begin
      // CR LF pair ends the line
      cr_d   = 1'b0;
      disc_d = 1'b0;
      len_d  = '0;
      if (!disc_q) begin
        if (strip_q) begin
          rb0_v = 1'b1;
          rb0   = '{out_byte: 8'h00, has_byte: 1'b0, frame_end: 1'b1, overflow: 1'b0};
        end else begin
          rb0_v = 1'b1;
          rb0   = '{out_byte: LfdByteCr, has_byte: 1'b1, frame_end: 1'b0, overflow: 1'b0};
          rb1_v = 1'b1;
          rb1   = '{out_byte: LfdByteLf, has_byte: 1'b1, frame_end: 1'b1, overflow: 1'b0};
        end
      end
    end else begin
      // a held CR that is not part of a pair becomes a line byte
      if (cr_q) begin
        cr_d = 1'b0;
        if (!disc_q) begin
          if (len_q >= max_length_q) begin
            ra_v   = 1'b1;
            ra     = '{out_byte: 8'h00, has_byte: 1'b0, frame_end: 1'b1, overflow: 1'b1};
            disc_a = 1'b1;
            len_a  = '0;
          end else begin
            ra_v  = 1'b1;
            ra    = '{out_byte: LfdByteCr, has_byte: 1'b1, frame_end: 1'b0, overflow: 1'b0};
            len_a = len_q + LENGTH_WIDTH'(1);
          end
        end
      end
      disc_d = disc_a;
      len_d  = len_a;
      if (is_lf && lf_ok) begin
        disc_d = 1'b0;
        len_d  = '0;
        if (!disc_a) begin
          rb0_v = 1'b1;
          if (strip_q) begin
            rb0 = '{out_byte: 8'h00, has_byte: 1'b0, frame_end: 1'b1, overflow: 1'b0};
          end else begin
            rb0 = '{out_byte: LfdByteLf, has_byte: 1'b1, frame_end: 1'b1, overflow: 1'b0};
          end
        end
      end else if (is_cr && crlf_ok) begin
        cr_d = 1'b1;
      end else if (!disc_a) begin
        rb0_v = 1'b1;
        if (len_a >= max_length_q) begin
          rb0    = '{out_byte: 8'h00, has_byte: 1'b0, frame_end: 1'b1, overflow: 1'b1};
          disc_d = 1'b1;
          len_d  = '0;
        end else begin
          rb0   = '{out_byte: in_byte_i, has_byte: 1'b1, frame_end: 1'b0, overflow: 1'b0};
          len_d = len_a + LENGTH_WIDTH'(1);
        end
      end
    end
  end

  // ra, when present, leaves room for one more result only
  assign push_o              = accept && (ra_v || rb0_v);
  assign push_entry_o.first  = ra_v ? ra : rb0;
  assign push_entry_o.second = ra_v ? rb0 : rb1;
  assign push_entry_o.two    = ra_v ? rb0_v : rb1_v;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      cr_q   <= 1'b0;
      disc_q <= 1'b0;
    end else if (accept) begin
      len_q  <= len_d;
      cr_q   <= cr_d;
      disc_q <= disc_d;
    end
  end

endmodule

// File: rtl/lfd_queue.sv
// ----------------------------------------------------------------------------
// lfd_queue
// Short queue of result entries between the front and back ends.
// ----------------------------------------------------------------------------
module lfd_queue #(
  parameter int unsigned DEPTH = lfd_pkg::LfdQueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  lfd_pkg::lfd_entry_t push_entry_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                head_valid_o,
  output lfd_pkg::lfd_entry_t head_entry_o
);
  import lfd_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  lfd_entry_t      mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o       = (count_q == CntW'(DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_entry_o = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

// File: rtl/lfd_back.sv
// ----------------------------------------------------------------------------
// lfd_back
// Unpacks queue entries into single results and drives the output register.
// ----------------------------------------------------------------------------
module lfd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                head_valid_i,
  input  lfd_pkg::lfd_entry_t head_entry_i,
  output logic                pop_o,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [7:0]          m_axis_tdata,  // out_byte
  output logic                m_axis_tlast,  // frame_end
  output logic [2:0]          m_axis_tuser   // has_byte, overflow, run_last
);
  import lfd_pkg::*;

  lfd_result_t out_q, pend_q;
  logic        out_valid_q, out_last_q, pend_valid_q;
  logic        load;

  // advance whenever the output register is empty or being taken
  assign load  = !out_valid_q || m_axis_tready;
  assign pop_o = load && !pend_valid_q && head_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else if (load) begin
      if (pend_valid_q) begin
        out_valid_q  <= 1'b1;
        pend_valid_q <= 1'b0;
      end else begin
        out_valid_q  <= head_valid_i;
        pend_valid_q <= head_valid_i && head_entry_i.two;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      if (pend_valid_q) begin
        out_q      <= pend_q;
        out_last_q <= 1'b1;
      end else begin
        out_q      <= head_entry_i.first;
        out_last_q <= !head_entry_i.two;
        pend_q     <= head_entry_i.second;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q.out_byte;
  assign m_axis_tlast  = out_q.frame_end;
  assign m_axis_tuser  = {out_last_q, out_q.overflow, out_q.has_byte};

endmodule

// File: rtl/line_frame_decoder.sv
// ----------------------------------------------------------------------------
// line_frame_decoder
// Splits a byte stream into LF, CR LF or either terminated frames.
// ----------------------------------------------------------------------------
// Path: the results of an accepted byte go into the queue, then into the output
//   register. Throughput: one byte per cycle in while the queue is not full;
//   one result per cycle out while m_axis_tready is high, so a byte that gives
//   two results (CR LF passed on) takes two output transfers.
// Reset: asynchronous, active low; clears line state, queue and output stage,
//   and loads the register defaults (max_length 4096, strip on, mode 0).
module line_frame_decoder #(
  parameter int unsigned LENGTH_WIDTH = lfd_pkg::LfdLengthWidth,
  parameter int unsigned QUEUE_DEPTH  = lfd_pkg::LfdQueueDepth
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // configuration writes: index 0 max_length, 1 strip_delimiter, 2 terminator_mode
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [1:0]              cfg_index_i,
  input  logic [LENGTH_WIDTH-1:0] cfg_data_i,
  // byte stream in
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [7:0]              s_axis_tdata,  // in_byte
  // results out
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [7:0]              m_axis_tdata,  // out_byte
  output logic                    m_axis_tlast,  // frame_end
  output logic [2:0]              m_axis_tuser   // has_byte, overflow, run_last
);
  import lfd_pkg::*;

  logic       push, queue_full, pop, head_valid;
  lfd_entry_t push_entry, head_entry;

  // Front end: hold the line state and turn each accepted byte into one
  // entry of up to two results. Bytes that give nothing (held CR, dropped
  // bytes of an overlong line) leave no entry.
  lfd_front #(
    .LENGTH_WIDTH(LENGTH_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .queue_full_i(queue_full),
    .push_o      (push),
    .push_entry_o(push_entry)
  );

  // Queue: absorb bursts of two-result bytes while the output is stalled.
  lfd_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_entry_i(push_entry),
    .full_o      (queue_full),
    .pop_i       (pop),
    .head_valid_o(head_valid),
    .head_entry_o(head_entry)
  );

  // Back end: issue results one transfer at a time and mark the last of
  // each byte's run.
  lfd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_entry_i (head_entry),
    .pop_o        (pop),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

endmodule

// File: rtl/lfd_checker.sv
// ----------------------------------------------------------------------------
// lfd_checker
// Port-level checks of the line frame decoder's result stream.
// ----------------------------------------------------------------------------
module lfd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast,
  input logic [2:0] m_axis_tuser
);

  // a stalled result stays offered
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // overflow carries no byte and closes the frame
  a_overflow_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> !m_axis_tuser[0] && m_axis_tlast)
    else $error("malformed overflow result");

  // a result without a byte always ends a frame
  a_empty_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast)
    else $error("byte-less result that does not end a frame");

  // a result without a byte shows a zero data byte
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 8'h00)
    else $error("non-zero data on byte-less result");

endmodule

bind line_frame_decoder lfd_checker u_lfd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tlast (m_axis_tlast),
  .m_axis_tuser (m_axis_tuser)
);

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the line frame decoder. A behavioural line splitter
// works out the expected results of each byte as it is accepted. Directed
// lines cover the terminator modes, delimiter stripping, overlong lines and a
// held CR across a mode change. Random well-formed lines with random noise
// follow, under several idle and stall patterns on both streams.
// ----------------------------------------------------------------------------
module testbench;
  import lfd_pkg::*;

  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned RandomBytes   = 2000;
  localparam int unsigned SubPhases     = 16;

  // tuser bit positions of a result
  localparam int unsigned UserHasByte  = 0;
  localparam int unsigned UserOverflow = 1;
  localparam int unsigned UserRunLast  = 2;

  typedef logic [7:0] byte_q_t[$];

  typedef struct {
    logic [7:0] out_byte;
    bit         has_byte;
    bit         frame_end;
    bit         overflow;
    bit         run_last;
  } frame_result_t;

  logic                      clk_i         = 1'b0;
  logic                      rst_ni        = 1'b0;
  logic                      cfg_valid_i   = 1'b0;
  logic                      cfg_ready_o;
  logic [1:0]                cfg_index_i   = '0;
  logic [LfdLengthWidth-1:0] cfg_data_i    = '0;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [7:0]                s_axis_tdata  = '0;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [7:0]                m_axis_tdata;
  logic                      m_axis_tlast;
  logic [2:0]                m_axis_tuser;

  // Expected results, oldest first
  frame_result_t expected_results[$];
  frame_result_t byte_results[$];

  // Line splitter state and its copy of the registers
  logic [16:0]   line_len;
  bit            cr_held;
  bit            dropping;
  logic [15:0]   max_len;
  bit            strip;
  lfd_mode_e     mode;

  int unsigned   send_idle_pct;
  int unsigned   recv_stall_pct;
  int unsigned   bytes_sent;
  int unsigned   error_count;
  int unsigned   idle_cycles;

  line_frame_decoder DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  always #2 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Line splitter
  // --------------------------------------------------------------------------
  function void add_result(logic [7:0] b, bit has, bit fend, bit ovf);
    frame_result_t r;
    r.out_byte  = b;
    r.has_byte  = has;
    r.frame_end = fend;
    r.overflow  = ovf;
    r.run_last  = 1'b0;
    byte_results.push_back(r);
  endfunction

  // Pass one content byte, or abort the line once it is already full
  function void pass_line_byte(logic [7:0] b);
    if (dropping) return;
    if (line_len >= {1'b0, max_len}) begin
      add_result(8'h00, 1'b0, 1'b1, 1'b1);
      dropping = 1'b1;
      line_len = '0;
      return;
    end
    add_result(b, 1'b1, 1'b0, 1'b0);
    line_len = line_len + 17'd1;
  endfunction

  // A terminator closes the frame, or silently ends a discard
  function void end_line(bit crlf);
    if (dropping) begin
      dropping = 1'b0;
      line_len = '0;
      return;
    end
    if (strip) begin
      add_result(8'h00, 1'b0, 1'b1, 1'b0);
    end else begin
      if (crlf) add_result(LfdByteCr, 1'b1, 1'b0, 1'b0);
      add_result(LfdByteLf, 1'b1, 1'b1, 1'b0);
    end
    line_len = '0;
  endfunction

  function void decode_byte(logic [7:0] b);
    bit crlf_ok;
    bit lf_ok;
    bit closed;
    crlf_ok = (mode != LfdModeLfOnly);
    lf_ok   = (mode != LfdModeCrLfOnly);
    closed  = 1'b0;
    byte_results.delete();
    // A held CR is judged under the mode in force now
    if (cr_held) begin
      cr_held = 1'b0;
      if (b == LfdByteLf && crlf_ok) begin
        end_line(1'b1);
        closed = 1'b1;
      end else begin
        pass_line_byte(LfdByteCr);
      end
    end
    if (!closed) begin
      if (b == LfdByteLf && lf_ok) end_line(1'b0);
      else if (b == LfdByteCr && crlf_ok) cr_held = 1'b1;
      else pass_line_byte(b);
    end
    if (byte_results.size() > 0) byte_results[byte_results.size()-1].run_last = 1'b1;
    foreach (byte_results[i]) expected_results.push_back(byte_results[i]);
  endfunction

  // --------------------------------------------------------------------------
  // Stream and register drivers
  // --------------------------------------------------------------------------
  // Hold tvalid across back-to-back transfers; drop it only while idling
  task automatic send_byte(logic [7:0] b);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    decode_byte(b);
    bytes_sent++;
  endtask

  task automatic send_bytes(byte_q_t bytes);
    foreach (bytes[i]) send_byte(bytes[i]);
  endtask

  // Hold the input off until every result is out, then let the pipe settle
  task automatic quiesce();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(lfd_reg_e idx, logic [LfdLengthWidth-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      LfdRegMaxLength: max_len = val;
      LfdRegStrip:     strip   = val[0];
      LfdRegMode:      mode    = lfd_mode_e'(val[1:0]);
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_idling(int unsigned phase);
    case (phase % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
      default: begin send_idle_pct = 30; recv_stall_pct = 30; end
    endcase
  endtask

  // Random stall on the result side
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // --------------------------------------------------------------------------
  // Result check
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_check
    frame_result_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: out_byte %0h tlast %0b tuser %0b",
               m_axis_tdata, m_axis_tlast, m_axis_tuser);
        error_count++;
      end else begin
        exp_r = expected_results.pop_front();
        if (exp_r.out_byte !== m_axis_tdata) begin
          $error("out_byte: expected %0h, got %0h", exp_r.out_byte, m_axis_tdata);
          error_count++;
        end
        if (exp_r.has_byte !== m_axis_tuser[UserHasByte]) begin
          $error("has_byte: expected %0b, got %0b", exp_r.has_byte,
                 m_axis_tuser[UserHasByte]);
          error_count++;
        end
        if (exp_r.frame_end !== m_axis_tlast) begin
          $error("frame_end: expected %0b, got %0b", exp_r.frame_end, m_axis_tlast);
          error_count++;
        end
        if (exp_r.overflow !== m_axis_tuser[UserOverflow]) begin
          $error("overflow: expected %0b, got %0b", exp_r.overflow,
                 m_axis_tuser[UserOverflow]);
          error_count++;
        end
        if (exp_r.run_last !== m_axis_tuser[UserRunLast]) begin
          $error("run_last: expected %0b, got %0b", exp_r.run_last,
                 m_axis_tuser[UserRunLast]);
          error_count++;
        end
      end
    end
  end

  // Count cycles without any transfer; a stuck handshake ends the run
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WatchdogLimit) begin
          $display("Regression FAIL");
          $finish;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Register defaults: strip on, either terminator, long lines allowed
  task automatic test_default_lines();
    send_bytes('{8'h00, 8'hFF, LfdByteLf});
    send_bytes('{LfdByteCr, LfdByteLf});
    send_bytes('{LfdByteCr, 8'h41, LfdByteLf});
  endtask

  // Terminators passed on; CR plain in LF-only mode, lone LF plain in CR LF mode
  task automatic test_delimiter_passthrough();
    quiesce();
    write_reg(LfdRegStrip, '0);
    write_reg(LfdRegMode, LfdLengthWidth'(LfdModeLfOnly));
    send_bytes('{LfdByteCr, LfdByteLf});
    quiesce();
    write_reg(LfdRegMode, LfdLengthWidth'(LfdModeCrLfOnly));
    send_bytes('{LfdByteLf, LfdByteCr, LfdByteLf});
  endtask

  // Zero length admits only empty lines; a line of exactly max_length passes
  task automatic test_overlong_lines();
    quiesce();
    write_reg(LfdRegMaxLength, '0);
    write_reg(LfdRegMode, LfdLengthWidth'(LfdModeAny));
    send_bytes('{LfdByteLf});
    send_bytes('{8'h7A, 8'h7B, LfdByteLf});
    quiesce();
    write_reg(LfdRegMaxLength, 16'd1);
    send_bytes('{8'h31, LfdByteLf});
    send_bytes('{8'h31, 8'h32, LfdByteCr, LfdByteLf});
  endtask

  // A CR held under mode 0 becomes a plain byte once LF-only is selected
  task automatic test_mode_change_held_cr();
    quiesce();
    write_reg(LfdRegMaxLength, 16'hFFFF);
    send_byte(LfdByteCr);
    quiesce();
    write_reg(LfdRegMode, LfdLengthWidth'(LfdModeLfOnly));
    send_byte(LfdByteLf);
  endtask

  task automatic test_random_traffic();
    byte_q_t     line;
    int unsigned sub;
    int unsigned len;
    int unsigned pick;
    int unsigned target;
    logic [15:0] len_choice[9];
    len_choice = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd5, 16'd8, 16'd13, 16'd20, 16'hFFFF};
    for (sub = 0; sub < SubPhases; sub++) begin
      set_idling(sub);
      quiesce();
      pick = $urandom_range(9);
      write_reg(LfdRegMaxLength, (pick < 9) ? len_choice[pick] : 16'($urandom));
      write_reg(LfdRegStrip, LfdLengthWidth'($urandom_range(1)));
      write_reg(LfdRegMode, LfdLengthWidth'($urandom_range(2)));
      target = bytes_sent + RandomBytes / SubPhases;
      while (bytes_sent < target) begin
        line.delete();
        if ($urandom_range(99) < 15) begin
          // Noise: raw bytes weighted towards the terminator codes
          repeat ($urandom_range(6, 1)) begin
            pick = $urandom_range(3);
            line.push_back(pick == 0 ? LfdByteLf : pick == 1 ? LfdByteCr :
                           8'($urandom_range(255)));
          end
        end else begin
          len = (max_len <= 16'd24) ? $urandom_range(max_len + 2) : $urandom_range(12);
          repeat (len) line.push_back(8'($urandom_range(255)));
          pick = $urandom_range(9);
          if (pick < 4) begin
            line.push_back(LfdByteLf);
          end else if (pick < 8) begin
            line.push_back(LfdByteCr);
            line.push_back(LfdByteLf);
          end else if (pick == 8) begin
            line.push_back(LfdByteCr);
            line.push_back(LfdByteCr);
            line.push_back(LfdByteLf);
          end else begin
            line.push_back(LfdByteCr);
            line.push_back(8'($urandom_range(255)));
          end
        end
        send_bytes(line);
      end
    end
  endtask

  initial begin
    line_len       = '0;
    cr_held        = 1'b0;
    dropping       = 1'b0;
    max_len        = 16'(LfdMaxLengthReset);
    strip          = 1'b1;
    mode           = LfdModeAny;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    bytes_sent     = 0;
    error_count    = 0;
    idle_cycles    = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_lines();
    test_delimiter_passthrough();
    test_overlong_lines();
    test_mode_change_held_cr();
    test_random_traffic();

    quiesce();
    repeat (16) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
